// ===== src/cfa_pkg.sv =====
// Package: constants, status codes and policy codes for the contiguous fit allocator.
package cfa_pkg;

    localparam int unsigned POOL_SIZE_DEF   = 1024;
    localparam int unsigned TABLE_DEPTH_DEF = 32;

    localparam int unsigned OWNER_W  = 16;
    localparam int unsigned REQ_W    = 11;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ADDR_W   = 10;
    localparam int unsigned FREE_W   = 11;
    localparam int unsigned HOLES_W  = 6;
    localparam int unsigned POLICY_W = 2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_GRANT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // policy codes
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;
    localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd3;

endpackage

// ===== src/contiguous_fit_allocator.sv =====
// Top level: segment table allocator with first, best, worst and next fit policies.
//
// Usage: s_ channel takes one request word (owner_id, request_size); m_
// channel returns one result word per request (status, start_address,
// free total, largest_free, hole_count). The cfg channel writes fit_policy;
// the user must write it only while the block is idle, which the block
// itself does not enforce. The segment table sits in one synchronous memory
// (one read, one write port, registered read data). A request runs through
// up to four passes: a scan of the live entries that chooses the segment,
// a shift of the later entries up by one when a remainder is split off
// (tail to head), the write of the chosen entry and of any remainder on a
// grant, and a sweep of the live entries that sums the free figures. First
// and next fit stop the scan at the first fitting segment. One request is
// worked at a time.
// After reset the table holds one free segment covering the pool; the
// remaining entries are never read before they are written. The result
// sits in an output register; a stalled receiver holds it and the block
// takes no new request until the result is taken.
module contiguous_fit_allocator
    import cfa_pkg::*;
#(
    parameter int unsigned POOL_SIZE   = POOL_SIZE_DEF,
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] owner_id, [26:16] request_size
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] status, [11:2] start_address,
                                   // [22:12] free total, [33:23] largest_free,
                                   // [39:34] hole_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // [1:0] fit_policy
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned SZ_W  = $clog2(POOL_SIZE + 1);
    localparam int unsigned ST_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [SZ_W-1:0]    size;
        logic [ST_W-1:0]    start;
        logic               used;
    } seg_t;

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // segment memory
    seg_t              mem [TABLE_DEPTH];
    seg_t              rd_data;
    logic [IDX_W-1:0]  rd_addr;
    logic              we;
    logic [IDX_W-1:0]  wr_addr;
    seg_t              wr_data;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    // control and payload registers
    logic [2:0]          state_reg, state_next;
    logic [POLICY_W-1:0] policy_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    cursor_reg, cursor_next;
    logic                init_reg;
    logic [OWNER_W-1:0]  owner_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [CNT_W-1:0]    n_reg, n_next;        // issue counter
    logic [IDX_W-1:0]    addr_reg, addr_next;  // address issued
    logic                pend_reg, pend_next;  // read data valid next cycle
    logic [IDX_W-1:0]    paddr_reg;            // address of data now in rd_data
    logic                found_reg, found_next;
    logic                done_reg, done_next;
    logic [IDX_W-1:0]    pick_reg, pick_next;
    seg_t                pseg_reg, pseg_next;
    logic                wstep_reg, wstep_next;
    logic [FREE_W-1:0]   tfree_reg, tfree_next;
    logic [FREE_W-1:0]   large_reg, large_next;
    logic [HOLES_W-1:0]  holes_reg, holes_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic [ADDR_W-1:0]   saddr_reg, saddr_next;

    logic [OWNER_W-1:0] in_owner;
    logic [REQ_W-1:0]   in_req;
    logic [IDX_W-1:0]   first_idx;
    logic               fit_ok, better, split;
    logic [SZ_W:0]      rem_size;
    logic [IDX_W-1:0]   wrap_addr;

    assign in_owner = s_tdata[OWNER_W-1:0];
    assign in_req   = s_tdata[OWNER_W+REQ_W-1:OWNER_W];
    assign s_tready = (state_reg == S_IDLE) && !init_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {holes_reg, large_reg, tfree_reg, saddr_reg, stat_reg};
    assign first_idx = ({{(CNT_W-IDX_W){1'b0}}, cursor_reg} < count_reg) ? cursor_reg : '0;

    // current entry tests
    assign fit_ok = !rd_data.used &&
                    ({{(SZ_W+1-REQ_W){1'b0}}, req_reg} <= {1'b0, rd_data.size});
    assign better = !found_reg ||
                    (policy_reg == POL_BEST  && rd_data.size < pseg_reg.size) ||
                    (policy_reg == POL_WORST && rd_data.size > pseg_reg.size);
    assign split  = {1'b0, pseg_reg.size} > {{(SZ_W+1-REQ_W){1'b0}}, req_reg};
    assign rem_size = {1'b0, pseg_reg.size} - {{(SZ_W+1-REQ_W){1'b0}}, req_reg};
    assign wrap_addr = ({{(CNT_W-IDX_W){1'b0}}, addr_reg} + 1'b1 >= count_reg)
                       ? '0 : addr_reg + 1'b1;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        n_next      = n_reg;
        addr_next   = addr_reg;
        pend_next   = 1'b0;
        found_next  = found_reg;
        done_next   = done_reg;
        pick_next   = pick_reg;
        pseg_next   = pseg_reg;
        wstep_next  = wstep_reg;
        tfree_next  = tfree_reg;
        large_next  = large_reg;
        holes_next  = holes_reg;
        stat_next   = stat_reg;
        saddr_next  = saddr_reg;
        rd_addr     = addr_reg;
        we          = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;

        case (state_reg)
            S_IDLE: begin
                if (init_reg) begin
                    we = 1'b1;
                    wr_data.size = SZ_W'(POOL_SIZE);
                end else if (s_tvalid) begin
                    state_next = S_SCAN;
                    n_next     = '0;
                    addr_next  = (policy_reg == POL_NEXT) ? first_idx : '0;
                    found_next = 1'b0;
                    done_next  = 1'b0;
                end
            end
            S_SCAN: begin
                // issue one read per cycle, evaluate data of the previous one
                if (!done_reg && n_reg < count_reg) begin
                    rd_addr   = addr_reg;
                    pend_next = 1'b1;
                    n_next    = n_reg + 1'b1;
                    addr_next = (policy_reg == POL_NEXT) ? wrap_addr : addr_reg + 1'b1;
                end
                if (pend_reg && !done_reg && fit_ok && better) begin
                    found_next = 1'b1;
                    pick_next  = paddr_reg;
                    pseg_next  = rd_data;
                    if (policy_reg == POL_FIRST || policy_reg == POL_NEXT) begin
                        done_next = 1'b1;
                    end
                end
                if (!pend_reg && (done_reg || n_reg >= count_reg)) begin
                    if (!found_reg) begin
                        stat_next  = ST_NOFIT;
                        saddr_next = '0;
                        state_next = S_SUM;
                        addr_next  = '0;
                        tfree_next = '0;
                        large_next = '0;
                        holes_next = '0;
                    end else if (split && count_reg >= CNT_W'(TABLE_DEPTH)) begin
                        stat_next  = ST_FULL;
                        saddr_next = '0;
                        state_next = S_SUM;
                        addr_next  = '0;
                        tfree_next = '0;
                        large_next = '0;
                        holes_next = '0;
                    end else begin
                        stat_next  = ST_GRANT;
                        saddr_next = ADDR_W'(pseg_reg.start);
                        if (policy_reg == POL_NEXT) begin
                            cursor_next = pick_reg;
                        end
                        if (split) begin
                            state_next = S_SHIFT;
                            addr_next  = IDX_W'(count_reg - 1'b1);
                        end else begin
                            state_next = S_WRITE;
                        end
                    end
                    wstep_next = 1'b0;
                    n_next     = '0;
                end
            end
            S_SHIFT: begin
                // move entries above the pick up one slot, tail first
                if (pend_reg) begin
                    we      = 1'b1;
                    wr_addr = paddr_reg + 1'b1;
                    wr_data = rd_data;
                end
                if (!pend_reg && !wstep_reg) begin
                    if (addr_reg > pick_reg) begin
                        rd_addr    = addr_reg;
                        pend_next  = 1'b1;
                        wstep_next = 1'b1;
                        addr_next  = addr_reg - 1'b1;
                    end else begin
                        state_next = S_WRITE;
                    end
                end else if (pend_reg) begin
                    wstep_next = 1'b0;
                end
            end
            S_WRITE: begin
                // chosen entry, then the remainder when a segment is split
                we = 1'b1;
                if (!wstep_reg) begin
                    wr_addr       = pick_reg;
                    wr_data.owner = owner_reg;
                    wr_data.size  = SZ_W'(req_reg);
                    wr_data.start = pseg_reg.start;
                    wr_data.used  = 1'b1;
                    wstep_next    = 1'b1;
                    if (!split) begin
                        state_next = S_SUM;
                    end
                end else begin
                    wr_addr       = pick_reg + 1'b1;
                    wr_data.size  = rem_size[SZ_W-1:0];
                    wr_data.start = pseg_reg.start + ST_W'(req_reg);
                    count_next    = count_reg + 1'b1;
                    state_next    = S_SUM;
                end
                n_next     = '0;
                addr_next  = '0;
                tfree_next = '0;
                large_next = '0;
                holes_next = '0;
            end
            S_SUM: begin
                if (n_reg < count_reg) begin
                    rd_addr   = addr_reg;
                    pend_next = 1'b1;
                    n_next    = n_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
                if (pend_reg && !rd_data.used) begin
                    tfree_next = tfree_reg + FREE_W'(rd_data.size);
                    holes_next = holes_reg + 1'b1;
                    if (FREE_W'(rd_data.size) > large_reg) begin
                        large_next = FREE_W'(rd_data.size);
                    end
                end
                if (!pend_reg && n_reg >= count_reg) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            policy_reg <= POL_FIRST;
            count_reg  <= CNT_W'(1);
            cursor_reg <= '0;
            init_reg   <= 1'b1;
            pend_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            init_reg   <= 1'b0;
            pend_reg   <= pend_next;
            if (cfg_valid) begin
                policy_reg <= cfg_data[POLICY_W-1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        addr_reg  <= addr_next;
        paddr_reg <= rd_addr;
        found_reg <= found_next;
        done_reg  <= done_next;
        pick_reg  <= pick_next;
        pseg_reg  <= pseg_next;
        wstep_reg <= wstep_next;
        stat_reg  <= stat_next;
        saddr_reg <= saddr_next;
        tfree_reg <= tfree_next;
        large_reg <= large_next;
        holes_reg <= holes_next;
        if (state_reg == S_IDLE && s_tvalid && s_tready) begin
            owner_reg <= in_owner;
            req_reg   <= in_req;
        end
    end

endmodule

// ===== src/cfa_checker.sv =====
// Checker: port level properties of the allocator, bound to the top level.
module cfa_checker
    import cfa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // no new request while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request taken while result pending");

    // refused requests report address zero
    a_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ST_GRANT |-> m_tdata[11:2] == '0)
        else $error("refusal with nonzero address");

    // status is a defined code
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status");

    // an accepted request does not produce a result in the next cycle
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result too early");

endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
